/* design/nsbe_pkg.sv */
// shared types and constants for the nsec type bitmap encoder
package nsbe_pkg;

  localparam int NUM_WINDOWS   = 256;
  localparam int WIN_W         = 8;
  localparam int CUR_W         = 9;
  localparam int WORDS_PER_WIN = 4;
  localparam int WORD_W        = 64;
  localparam int RAM_DEPTH     = 1024;
  localparam int ADDR_W        = 10;
  localparam int GRP           = 8;
  localparam int GRP_W         = 3;
  localparam int CNT_W         = 14;
  localparam int LEN_W         = 6;
  localparam int IN_DATA_W     = 16;
  localparam int OUT_DATA_W    = 288;

  localparam logic [CNT_W-1:0] CAP_RESET = 14'd8704;

  // request codes on in_tuser
  typedef enum logic [1:0] {
    REQ_ADD,
    REQ_READ,
    REQ_CLEAR
  } req_t;

  // result status on out_tuser
  typedef enum logic [1:0] {
    ST_WINDOW,
    ST_FINISHED,
    ST_OVERFLOW
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADD_INIT,
    S_ADD_RD,
    S_ADD_WR,
    S_SCAN,
    S_FETCH,
    S_CHECK,
    S_RESULT
  } st_t;

  // window flag control from the sequencer
  typedef struct packed {
    logic             set_en;
    logic [WIN_W-1:0] set_idx;
    logic             clr_all;
  } flag_ctl_t;

  // result of one scan step over a group of window flags
  typedef struct packed {
    logic             hit;
    logic [WIN_W-1:0] idx;
  } flag_hit_t;

endpackage

/* design/nsbe_word_ram.sv */
// bitmap word memory, one write port and one registered read port
module nsbe_word_ram (
  input  logic                        clk,
  input  logic                        we,
  input  logic [nsbe_pkg::ADDR_W-1:0] waddr,
  input  logic [nsbe_pkg::WORD_W-1:0] wdata,
  input  logic [nsbe_pkg::ADDR_W-1:0] raddr,
  output logic [nsbe_pkg::WORD_W-1:0] rdata
);
  import nsbe_pkg::*;

  logic [WORD_W-1:0] mem [RAM_DEPTH];
  logic [WORD_W-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* design/nsbe_win_flags.sv */
// window in-use flags with a clear of all flags at once and an eight-flag scan step
module nsbe_win_flags (
  input  logic                       clk,
  input  logic                       rst_n,
  input  nsbe_pkg::flag_ctl_t        ctl,
  input  logic [nsbe_pkg::WIN_W-1:0] probe_idx,
  output logic                       probe_used,
  input  logic [nsbe_pkg::CUR_W-1:0] scan_from,
  output nsbe_pkg::flag_hit_t        hit
);
  import nsbe_pkg::*;

  logic [NUM_WINDOWS-1:0] used_r;
  logic [GRP-1:0]         grp;
  logic [GRP_W-1:0]       lo;

  // flag storage, cleared by reset or a clear request
  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clr_all) begin
      used_r <= '0;
    end else if (ctl.set_en) begin
      used_r[ctl.set_idx] <= 1'b1;
    end
  end

  assign probe_used = used_r[probe_idx];

  // lowest set flag at or above the cursor within its group of eight
  assign grp = used_r[{scan_from[WIN_W-1:GRP_W], {GRP_W{1'b0}}} +: GRP];
  assign lo  = scan_from[GRP_W-1:0];

  always_comb begin
    hit.hit = 1'b0;
    hit.idx = '0;
    for (int j = GRP - 1; j >= 0; j--) begin
      if (grp[j] && (GRP_W'(j) >= lo)) begin
        hit.hit = 1'b1;
        hit.idx = {scan_from[WIN_W-1:GRP_W], GRP_W'(j)};
      end
    end
  end

endmodule

/* design/nsec_type_bitmap_encoder.sv */
// nsec type bitmap encoder top level: request sequencer, length unit and result register
// add: read-modify-write of one word for a window in use; the first type of a window writes all 4 words
// read: scan over groups of eight window flags (1 to 32), then word fetch, capacity check and result;
//   a finished read ends its scan in the result, an overflowed read skips the scan; results wait on out_tready
// clear and unused codes return straight to idle; one transaction in work at a time
// reset clears flags, cursor, count and overflow and sets capacity to 8704;
//   no memory sweep, words of a window are rewritten on its first add
module nsec_type_bitmap_encoder (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [nsbe_pkg::IN_DATA_W-1:0]  in_tdata,   // [15:0] rr_type
  input  logic [1:0]                      in_tuser,   // [1:0] req_type
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [nsbe_pkg::OUT_DATA_W-1:0] out_tdata,  // [7:0] window_number,
                                                      // [13:8] bitmap_length,
                                                      // [77:14] bitmap_bytes_0_7,
                                                      // [141:78] bitmap_bytes_8_15,
                                                      // [205:142] bitmap_bytes_16_23,
                                                      // [269:206] bitmap_bytes_24_31,
                                                      // [283:270] bytes_used, [287:284] zero
  output logic [1:0]                      out_tuser,  // [1:0] status
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [nsbe_pkg::CNT_W-1:0]      cfg_data
);
  import nsbe_pkg::*;

  st_t                   state_r, state_nxt;
  logic [IN_DATA_W-1:0]  rr_r, rr_nxt;
  logic [WIN_W-1:0]      win_r, win_nxt;
  logic [2:0]            cnt_r, cnt_nxt;
  logic [WORD_W-1:0]     words_r [WORDS_PER_WIN];
  logic [WORD_W-1:0]     words_nxt [WORDS_PER_WIN];
  logic [LEN_W-1:0]      len_r, len_nxt;
  logic [CUR_W-1:0]      cursor_r, cursor_nxt;
  logic [CNT_W-1:0]      used_r, used_nxt;
  logic                  ovf_r, ovf_nxt;
  status_t               res_st_r, res_st_nxt;
  logic [CNT_W-1:0]      cap_r;
  logic                  out_tvalid_r, out_tvalid_nxt;
  logic [OUT_DATA_W-1:0] out_tdata_r, out_tdata_nxt;
  logic [1:0]            out_tuser_r, out_tuser_nxt;

  logic                  in_fire;
  logic                  out_free;
  logic                  add_in_range;
  logic [WORD_W-1:0]     add_bit;
  logic                  ram_we;
  logic [ADDR_W-1:0]     ram_waddr;
  logic [WORD_W-1:0]     ram_wdata;
  logic [ADDR_W-1:0]     ram_raddr;
  logic [WORD_W-1:0]     ram_rdata;
  flag_ctl_t             flag_ctl;
  logic                  probe_used;
  flag_hit_t             scan_hit;
  logic [2:0]            last_byte;
  logic                  byte_any;
  logic [1:0]            fetch_k;
  logic [CNT_W:0]        need_sum;

  nsbe_word_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  nsbe_win_flags u_flags (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (flag_ctl),
    .probe_idx  (in_tdata[IN_DATA_W-1:IN_DATA_W-WIN_W]),
    .probe_used (probe_used),
    .scan_from  (cursor_r),
    .hit        (scan_hit)
  );

  assign in_tready    = (state_r == S_IDLE);
  assign in_fire      = in_tvalid && in_tready;
  assign out_free     = !out_tvalid_r || out_tready;
  assign cfg_ready    = 1'b1;
  assign add_in_range = ({1'b0, in_tdata[IN_DATA_W-1:IN_DATA_W-WIN_W]} < CUR_W'(NUM_WINDOWS));
  assign add_bit      = {1'b1, {(WORD_W-1){1'b0}}} >> rr_r[5:0];
  assign fetch_k      = 2'(cnt_r - 3'd1);
  assign need_sum     = {1'b0, used_r} + (CNT_W+1)'(len_r) + (CNT_W+1)'(2);

  // length unit: last nonzero byte of the word coming out of the memory
  always_comb begin
    last_byte = '0;
    byte_any  = 1'b0;
    for (int j = 0; j < 8; j++) begin
      if (ram_rdata[WORD_W-1-8*j -: 8] != 8'h00) begin
        last_byte = 3'(j);
        byte_any  = 1'b1;
      end
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          case (in_tuser)
            REQ_ADD: begin
              if (add_in_range) begin
                state_nxt = probe_used ? S_ADD_RD : S_ADD_INIT;
              end
            end
            REQ_READ: state_nxt = ovf_r ? S_RESULT : S_SCAN;
            default:  state_nxt = S_IDLE;
          endcase
        end
      end
      S_ADD_INIT: begin
        if (cnt_r == 3'(WORDS_PER_WIN - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_ADD_RD: state_nxt = S_ADD_WR;
      S_ADD_WR: state_nxt = S_IDLE;
      S_SCAN: begin
        if (cursor_r >= CUR_W'(NUM_WINDOWS)) begin
          state_nxt = S_RESULT;
        end else if (scan_hit.hit) begin
          state_nxt = S_FETCH;
        end
      end
      S_FETCH: begin
        if (cnt_r == 3'(WORDS_PER_WIN)) begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: state_nxt = S_RESULT;
      S_RESULT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and control outputs
  always_comb begin
    rr_nxt     = rr_r;
    win_nxt    = win_r;
    cnt_nxt    = cnt_r;
    words_nxt  = words_r;
    len_nxt    = len_r;
    cursor_nxt = cursor_r;
    used_nxt   = used_r;
    ovf_nxt    = ovf_r;
    res_st_nxt = res_st_r;
    ram_we     = 1'b0;
    ram_waddr  = rr_r[IN_DATA_W-1:IN_DATA_W-ADDR_W];
    ram_wdata  = ram_rdata | add_bit;
    ram_raddr  = rr_r[IN_DATA_W-1:IN_DATA_W-ADDR_W];
    flag_ctl   = '0;

    // result register drains on its own handshake
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_tdata_nxt  = out_tdata_r;
    out_tuser_nxt  = out_tuser_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          case (in_tuser)
            REQ_ADD: begin
              rr_nxt  = in_tdata;
              cnt_nxt = '0;
              if (add_in_range && !probe_used) begin
                flag_ctl.set_en  = 1'b1;
                flag_ctl.set_idx = in_tdata[IN_DATA_W-1:IN_DATA_W-WIN_W];
              end
            end
            REQ_READ: begin
              res_st_nxt = ST_OVERFLOW;
            end
            REQ_CLEAR: begin
              flag_ctl.clr_all = 1'b1;
              cursor_nxt       = '0;
              used_nxt         = '0;
              ovf_nxt          = 1'b0;
            end
            default: begin
            end
          endcase
        end
      end
      // first type of a window: write all its words, stale data included
      S_ADD_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = {rr_r[IN_DATA_W-1:IN_DATA_W-WIN_W], cnt_r[1:0]};
        ram_wdata = (cnt_r[1:0] == rr_r[7:6]) ? add_bit : '0;
        cnt_nxt   = cnt_r + 3'd1;
      end
      S_ADD_RD: begin
      end
      // read-modify-write of the word holding the type
      S_ADD_WR: begin
        ram_we = 1'b1;
      end
      // step the cursor over eight window flags per cycle
      S_SCAN: begin
        if (cursor_r >= CUR_W'(NUM_WINDOWS)) begin
          res_st_nxt = ST_FINISHED;
        end else if (scan_hit.hit) begin
          win_nxt = scan_hit.idx;
          cnt_nxt = '0;
          len_nxt = '0;
        end else begin
          cursor_nxt = {cursor_r[CUR_W-1:GRP_W] + (CUR_W-GRP_W)'(1), {GRP_W{1'b0}}};
        end
      end
      // issue word reads and fold each returned word into the length
      S_FETCH: begin
        ram_raddr = {win_r, cnt_r[1:0]};
        cnt_nxt   = cnt_r + 3'd1;
        if (cnt_r != 3'd0) begin
          words_nxt[fetch_k] = ram_rdata;
          if (byte_any) begin
            len_nxt = LEN_W'({fetch_k, last_byte}) + LEN_W'(1);
          end
        end
      end
      // capacity check against the running count
      S_CHECK: begin
        if (need_sum > {1'b0, cap_r}) begin
          ovf_nxt    = 1'b1;
          res_st_nxt = ST_OVERFLOW;
        end else begin
          used_nxt   = need_sum[CNT_W-1:0];
          cursor_nxt = {1'b0, win_r} + CUR_W'(1);
          res_st_nxt = ST_WINDOW;
        end
      end
      // load the result register once it is free
      S_RESULT: begin
        if (out_free) begin
          out_tvalid_nxt = 1'b1;
          out_tuser_nxt  = res_st_r;
          if (res_st_r == ST_WINDOW) begin
            out_tdata_nxt = {4'b0, used_r, words_r[3], words_r[2], words_r[1], words_r[0],
                             len_r, win_r};
          end else begin
            out_tdata_nxt = {4'b0, used_r, {(4*WORD_W){1'b0}}, {LEN_W{1'b0}}, {WIN_W{1'b0}}};
          end
        end
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cursor_r     <= '0;
      used_r       <= '0;
      ovf_r        <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cursor_r     <= cursor_nxt;
      used_r       <= used_nxt;
      ovf_r        <= ovf_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  // capacity register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      cap_r <= cfg_data;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    rr_r        <= rr_nxt;
    win_r       <= win_nxt;
    cnt_r       <= cnt_nxt;
    words_r     <= words_nxt;
    len_r       <= len_nxt;
    res_st_r    <= res_st_nxt;
    out_tdata_r <= out_tdata_nxt;
    out_tuser_r <= out_tuser_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  // a clear transaction resets cursor, count and overflow
  a_clear_resets: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_tuser == REQ_CLEAR) |=> (cursor_r == '0 && used_r == '0 && !ovf_r))
    else $error("clear did not reset read state");

  // overflow stays until a clear
  a_ovf_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (ovf_r && !(in_fire && in_tuser == REQ_CLEAR)) |=> ovf_r)
    else $error("overflow flag dropped without clear");

  // non-window results carry no window number or length
  a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser != ST_WINDOW) |-> (out_tdata[13:0] == '0))
    else $error("non-window result has window fields");

  // an emitted window has a length of 1 to 32
  a_window_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == ST_WINDOW) |->
      (out_tdata[13:8] != '0 && out_tdata[13:8] <= 6'd32))
    else $error("emitted window length out of range");

endmodule
